// File: rtl/core/dewf_pkg.sv
// ----------------------------------------------------------------------------
// dewf_pkg
// Shared types and constants of the duplicate event window filter: field
// widths, register indexes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dewf_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 16;

  localparam int unsigned CODE_W     = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_MODE = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_FINISH
  } dewf_state_t;

  typedef struct packed {
    logic load_in;     // capture the input beat
    logic eval;        // check the window, arm the history search
    logic search_run;  // advance the history search by one entry
    logic commit;      // apply the decision and load the output register
  } dewf_cmd_t;

  typedef struct packed {
    logic skip;         // no search needed: single mode or window expired
    logic search_done;  // code found or all filled entries compared
  } dewf_status_t;

endpackage

// File: rtl/core/dewf_if.sv
// ----------------------------------------------------------------------------
// dewf_in_if / dewf_out_if
// Valid/ready channels of the duplicate event window filter: event beats in,
// decision beats out.
// ----------------------------------------------------------------------------
interface dewf_in_if;
  logic                        valid;
  logic                        ready;
  logic [dewf_pkg::CODE_W-1:0] event_code;
  logic [dewf_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output event_code, output now_ms, input ready);
  modport sink (input valid, input event_code, input now_ms, output ready);
endinterface

interface dewf_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink (input valid, input accepted, output ready);
endinterface

// File: rtl/core/dewf_ctrl.sv
// ----------------------------------------------------------------------------
// dewf_ctrl
// Sequencer of the filter: takes one event beat, steps the datapath through
// window check and history search, and owns the output valid flag.
// ----------------------------------------------------------------------------
module dewf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  dewf_pkg::dewf_status_t status,
  output dewf_pkg::dewf_cmd_t    cmd
);

  dewf_pkg::dewf_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dewf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      dewf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = dewf_pkg::ST_EVAL;
        end
      end
      dewf_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = dewf_pkg::ST_SEARCH;
      end
      dewf_pkg::ST_SEARCH: begin
        if (status.skip || status.search_done) begin
          state_nxt = dewf_pkg::ST_FINISH;
        end else begin
          cmd.search_run = 1'b1;
        end
      end
      dewf_pkg::ST_FINISH: begin
        // hold until the output register can take the decision
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dewf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dewf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/dewf_dp.sv
// ----------------------------------------------------------------------------
// dewf_dp
// Datapath of the filter: configuration registers, history ring memory,
// window compare, one-entry-per-cycle search and the state update.
// ----------------------------------------------------------------------------
module dewf_dp #(
  parameter int unsigned HISTORY_DEPTH = dewf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dewf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dewf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [dewf_pkg::CODE_W-1:0]     in_event_code,
  input  logic [dewf_pkg::TIME_W-1:0]     in_now_ms,
  input  dewf_pkg::dewf_cmd_t             cmd,
  output dewf_pkg::dewf_status_t          status,
  output logic                            out_accepted
);

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(HISTORY_DEPTH);

  logic [dewf_pkg::CODE_W-1:0] hist_mem [HISTORY_DEPTH];

  logic [dewf_pkg::TIME_W-1:0] window_r;
  logic                        list_mode_r;
  logic [dewf_pkg::CODE_W-1:0] code_r;
  logic [dewf_pkg::TIME_W-1:0] now_r;
  logic [dewf_pkg::TIME_W-1:0] lat_r;
  logic [dewf_pkg::CODE_W-1:0] last_code_r;
  logic [CW-1:0]               fill_r;
  logic [AW-1:0]               wp_r;
  logic                        expired_r;
  logic                        found_r;
  logic                        pend_r;
  logic [CW-1:0]               idx_r;
  logic [dewf_pkg::CODE_W-1:0] rd_data_r;
  logic                        out_acc_r;

  logic [dewf_pkg::TIME_W-1:0] elapsed;
  logic                        acc;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               wp_nxt;
  logic [CW-1:0]               fill_nxt;
  logic                        issue;
  logic                        hist_we;

  // Window age modulo 2^32
  assign elapsed = now_r - lat_r;

  assign acc = list_mode_r ? (expired_r || !found_r)
                           : ((code_r != last_code_r) || expired_r);

  // An expired window empties the ring, so the code lands in slot zero
  assign wr_addr  = expired_r ? '0 : wp_r;
  assign wp_nxt   = (wr_addr == LAST_SLOT) ? '0 : wr_addr + AW'(1);
  assign fill_nxt = expired_r ? CW'(1) : ((fill_r == FULL) ? fill_r : fill_r + CW'(1));

  assign issue   = cmd.search_run && (idx_r < fill_r);
  assign hist_we = cmd.commit && acc && list_mode_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '0;
      list_mode_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        dewf_pkg::REG_WINDOW_MS: window_r    <= cfg_data[dewf_pkg::TIME_W-1:0];
        dewf_pkg::REG_LIST_MODE: list_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // History ring
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wr_addr] <= code_r;
    end
    if (issue) begin
      rd_data_r <= hist_mem[idx_r[AW-1:0]];
    end
  end

  // Input capture, window check, output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      code_r <= in_event_code;
      now_r  <= in_now_ms;
    end
    if (cmd.eval) begin
      expired_r <= (elapsed >= window_r);
    end
    if (cmd.commit) begin
      out_acc_r <= acc;
    end
  end

  // Search control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      lat_r       <= '0;
      last_code_r <= '0;
    end else begin
      if (cmd.eval) begin
        found_r <= 1'b0;
        pend_r  <= 1'b0;
        idx_r   <= '0;
      end else if (cmd.search_run) begin
        pend_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CW'(1);
        end
        if (pend_r && (rd_data_r == code_r)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit && acc) begin
        lat_r <= now_r;
        if (list_mode_r) begin
          wp_r   <= wp_nxt;
          fill_r <= fill_nxt;
        end else begin
          last_code_r <= code_r;
        end
      end
    end
  end

  assign status.skip        = !list_mode_r || expired_r;
  assign status.search_done = found_r || (!pend_r && (idx_r >= fill_r));
  assign out_accepted       = out_acc_r;

endmodule

// File: rtl/core/duplicate_event_window_filter.sv
// Steps per event: capture, window check, history search and commit. The search
//   ends at once in single mode, with an expired window or an empty ring.
// Throughput: one event at a time; the history memory port reads one entry per
//   cycle, so the search sets the rate.
// Reset (synchronous, rst_n low): window 0, list mode on, history empty, timer
//   and last code cleared; no clearing pass, the fill count bounds the search.
// ----------------------------------------------------------------------------
// duplicate_event_window_filter
// Passes an event on or suppresses it as a repeat seen inside a time window,
// against a ring of recently accepted codes or against the last one alone.
// ----------------------------------------------------------------------------
module duplicate_event_window_filter #(
  parameter int unsigned HISTORY_DEPTH = dewf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dewf_in_if.sink                         in_ch,
  dewf_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dewf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dewf_pkg::CFG_DATA_W-1:0] cfg_data
);

  dewf_pkg::dewf_cmd_t    cmd;
  dewf_pkg::dewf_status_t status;

  // Controller: one beat in, sequence the steps, hold the result until taken.
  // A new beat is taken while the previous decision still waits at the output.
  dewf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: the window check is a 32-bit subtract and compare, registered
  // before any decision; the search compares one ring entry per cycle
  // against the registered code and stops at the first hit.
  dewf_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .in_event_code (in_ch.event_code),
    .in_now_ms     (in_ch.now_ms),
    .cmd           (cmd),
    .status        (status),
    .out_accepted  (out_ch.accepted)
  );

  // One event in flight: a taken beat blocks the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again while an event is in flight");

  // A commit always presents a decision beat on the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("decision committed but not presented");

  // The search only runs when the ring has to be consulted
  a_search_needed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search_run |-> (!status.skip && !status.search_done))
    else $error("history search advanced when not needed");

  // Commit and input capture never coincide
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !in_ch.ready)
    else $error("commit while the input side is open");

endmodule

// File: tb/sv/dewf_decision_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dewf_decision_checker
// Watches the event, decision and register ports of the duplicate event
// window filter, keeps its own copy of the filter state, predicts the
// decision for every accepted event beat and compares it with the decision
// beats in order.
// ----------------------------------------------------------------------------
module dewf_decision_checker #(
  parameter int unsigned DEPTH = dewf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dewf_in_if                              in_mon,
  dewf_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [dewf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dewf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);

  typedef struct {
    logic [dewf_pkg::CODE_W-1:0] code;
    logic [dewf_pkg::TIME_W-1:0] now;
    bit                          passed;
  } decision_t;

  // Filter state as this checker sees it
  logic [dewf_pkg::TIME_W-1:0] win_ms;
  bit                          list_on;
  logic [dewf_pkg::CODE_W-1:0] ring_codes [DEPTH];
  int unsigned                 ring_fill;
  int unsigned                 ring_wr;
  logic [dewf_pkg::TIME_W-1:0] last_pass_ms;
  logic [dewf_pkg::CODE_W-1:0] last_pass_code;

  decision_t decision_q [$];

  // Decide one event and update the state as the filter does.
  function automatic bit decide_event(input logic [dewf_pkg::CODE_W-1:0] code,
                                      input logic [dewf_pkg::TIME_W-1:0] now);
    logic [dewf_pkg::TIME_W-1:0] elapsed;
    bit                          seen;
    bit                          pass;
    int unsigned                 i;
    elapsed = now - last_pass_ms;
    if (list_on) begin
      if (elapsed >= win_ms && ring_fill > 0) begin
        ring_fill    = 0;
        ring_wr      = 0;
        last_pass_ms = now;
      end
      seen = 1'b0;
      for (i = 0; i < ring_fill; i++) begin
        if (ring_codes[i] == code) seen = 1'b1;
      end
      elapsed = now - last_pass_ms;
      pass    = !seen || (elapsed >= win_ms);
      if (pass) begin
        ring_codes[ring_wr] = code;
        ring_wr             = (ring_wr == DEPTH - 1) ? 0 : ring_wr + 1;
        if (ring_fill < DEPTH) ring_fill++;
        last_pass_ms = now;
      end
    end else begin
      pass = (code != last_pass_code) || (elapsed >= win_ms);
      if (pass) begin
        last_pass_code = code;
        last_pass_ms   = now;
      end
    end
    return pass;
  endfunction

  always @(posedge clk) begin
    decision_t head;
    decision_t fresh;
    if (!rst_n) begin
      win_ms         = '0;
      list_on        = 1'b1;
      ring_fill      = 0;
      ring_wr        = 0;
      last_pass_ms   = '0;
      last_pass_code = '0;
      fail_count     = 0;
      decision_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          dewf_pkg::REG_WINDOW_MS: win_ms  = cfg_data;
          dewf_pkg::REG_LIST_MODE: list_on = cfg_data[0];
          default: ;
        endcase
      end
      // Retire the decision beat before queuing a new event beat.
      if (out_mon.valid && out_mon.ready) begin
        if (decision_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected decision beat: expected none, got accepted=%0b",
                   $time, out_mon.accepted);
        end else begin
          head = decision_q.pop_front();
          if (out_mon.accepted !== head.passed) begin
            fail_count++;
            $display("%0t: code %0d at %0d ms: expected accepted=%0b, got %0b",
                     $time, head.code, head.now, head.passed, out_mon.accepted);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        fresh.code   = in_mon.event_code;
        fresh.now    = in_mon.now_ms;
        fresh.passed = decide_event(in_mon.event_code, in_mon.now_ms);
        decision_q.push_back(fresh);
      end
    end
    pending = decision_q.size();
  end

endmodule

// File: tb/sv/tb_duplicate_event_window_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_duplicate_event_window_filter
// Drives event beats into the duplicate event window filter under changing
// window and mode settings: a short directed run over the corner cases, then
// random phases of clustered codes and times, with random idling on both
// channels and one long decision stall. A checker beside the block predicts
// and compares every decision.
// ----------------------------------------------------------------------------
module tb_duplicate_event_window_filter;

  localparam int unsigned LIMIT_CYCLES   = 1_000_000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_EVENTS   = 180;
  localparam int unsigned PRESSURE_BEATS = 24;

  // Window and mode per random phase; phase 5 draws its window at random.
  localparam logic [dewf_pkg::TIME_W-1:0] PHASE_WIN [NUM_PHASES] = '{
    32'd100, 32'd100, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1
  };
  localparam bit PHASE_LIST [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1};

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [dewf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [dewf_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     fail_count;
  int unsigned                     pending;
  bit                              hold_req;
  int unsigned                     cycles;

  dewf_in_if  in_ch ();
  dewf_out_if out_ch ();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  duplicate_event_window_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  dewf_decision_checker decision_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle length: mostly a few cycles, now and then a long pause.
  function automatic int unsigned idle_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one event beat after a gap and hold it until the block takes it.
  task automatic send_event(input logic [dewf_pkg::CODE_W-1:0] code,
                            input logic [dewf_pkg::TIME_W-1:0] now,
                            input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.event_code <= code;
    in_ch.now_ms     <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every queued decision has come out.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [dewf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dewf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Decision side: random ready with stalls, steady stretches, and one long
  // hold-off on request so the block backs up and stalls its event input.
  initial begin : decision_sink
    bit          steady;
    bit          hold_served;
    int unsigned run_left;
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    hold_served  = 1'b0;
    run_left     = 0;
    stall_left   = 0;
    steady       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (run_left == 0) begin
          steady   = ($urandom_range(3) == 0);
          run_left = $urandom_range(20, 150);
        end
        run_left--;
        if (steady) begin
          out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(3) == 0) begin
          stall_left = idle_len() - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL duplicate_event_window_filter");
    $finish;
  end

  initial begin : event_source
    int unsigned                 p;
    int unsigned                 k;
    int unsigned                 pool;
    int unsigned                 run_left;
    int unsigned                 gap;
    int unsigned                 r;
    bit                          steady;
    logic [dewf_pkg::CODE_W-1:0] base;
    logic [dewf_pkg::CODE_W-1:0] code;
    logic [dewf_pkg::TIME_W-1:0] t;
    logic [dewf_pkg::TIME_W-1:0] w;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.event_code = '0;
    in_ch.now_ms     = '0;
    cfg_we           = 1'b0;
    cfg_idx          = dewf_pkg::REG_WINDOW_MS;
    cfg_data         = '0;
    hold_req         = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Zero window after reset: even an immediate repeat passes.
    send_event(8'h00, 32'd0, 0);
    send_event(8'h00, 32'd0, 0);

    // Fill the ring with sixteen codes, overwrite the oldest, then bring the
    // overwritten code back: it must pass again.
    drain();
    write_reg(dewf_pkg::REG_WINDOW_MS, 32'd100);
    for (k = 0; k < 16; k++) send_event(dewf_pkg::CODE_W'(10 + k), 32'd1000 + k, 0);
    send_event(8'd26, 32'd1016, 0);
    send_event(8'd10, 32'd1017, 0);

    // Time wrap: a repeat just past the 2^32 boundary is still inside.
    send_event(8'hFF, 32'hFFFF_FFFF, 0);
    send_event(8'hFF, 32'h0000_0030, 0);

    // Single mode: new code, repeat inside the window, different code.
    drain();
    write_reg(dewf_pkg::REG_LIST_MODE, 32'd0);
    send_event(8'hFF, 32'h0000_0040, 0);
    send_event(8'hFF, 32'h0000_0050, 0);
    send_event(8'h00, 32'h0000_0060, 0);

    // Random phases: codes cluster in a small pool so repeats and ring
    // overflow are common; times mostly creep, sometimes land near the
    // window edge, sometimes jump, and a few beats are pure noise.
    run_left = 0;
    steady   = 1'b0;
    for (p = 0; p < NUM_PHASES; p++) begin
      w = (p == 5) ? dewf_pkg::TIME_W'($urandom_range(1, 5000)) : PHASE_WIN[p];
      drain();
      write_reg(dewf_pkg::REG_WINDOW_MS, w);
      write_reg(dewf_pkg::REG_LIST_MODE, dewf_pkg::CFG_DATA_W'(PHASE_LIST[p]));
      base = dewf_pkg::CODE_W'($urandom);
      pool = $urandom_range(3, 24);
      t    = p[0] ? (32'hFFFF_FFFF - $urandom_range(2000)) : dewf_pkg::TIME_W'($urandom);
      // Stall the decision side while the first beats go in back to back.
      if (p == 0) hold_req = 1'b1;
      for (k = 0; k < PHASE_EVENTS; k++) begin
        r = $urandom_range(99);
        if (r < 5) begin
          code = dewf_pkg::CODE_W'($urandom);
          t    = $urandom;
        end else begin
          code = ($urandom_range(9) == 0)
                 ? dewf_pkg::CODE_W'($urandom)
                 : base + dewf_pkg::CODE_W'($urandom_range(pool - 1));
          if (r < 65)      t = t + $urandom_range(0, w / 32 + 1);
          else if (r < 90) t = t + w - 2 + $urandom_range(4);
          else             t = t + $urandom;
        end
        if (run_left == 0) begin
          steady   = ($urandom_range(2) == 0);
          run_left = $urandom_range(10, 60);
        end
        run_left--;
        if ((p == 0 && k < PRESSURE_BEATS) || steady) gap = 0;
        else gap = $urandom_range(1) ? 0 : idle_len();
        send_event(code, t, gap);
      end
    end

    // Let the last decisions out, then give the block time to settle.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS duplicate_event_window_filter");
    end else begin
      $display("FAIL duplicate_event_window_filter");
    end
    $finish;
  end

endmodule
